[rtl/core/multistage_graph_shortest_path_defines.svh]
// Assertion macros used by the checker file of the block.
`ifndef MULTISTAGE_GRAPH_SHORTEST_PATH_DEFINES_SVH
`define MULTISTAGE_GRAPH_SHORTEST_PATH_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define MGSP_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define MGSP_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

[rtl/core/mgsp_pkg.sv]
package mgsp_pkg;

   localparam int NODE_BITS         = 4;
   localparam int COST_BITS         = 20;
   localparam int WEIGHT_FIELD_BITS = 16;
   localparam int COUNT_BITS        = 5;
   localparam int RESULT_LIMIT      = 16;

   localparam logic [COST_BITS-1:0]  COST_MAX         = '1;
   localparam logic [COUNT_BITS-1:0] NODE_COUNT_RESET = 5'd16;

   localparam logic [1:0] OP_LOAD  = 2'd0;
   localparam logic [1:0] OP_SOLVE = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   typedef struct packed {
      logic [1:0]                   op;
      logic [NODE_BITS-1:0]         from_node;
      logic [NODE_BITS-1:0]         to_node;
      logic [WEIGHT_FIELD_BITS-1:0] weight;
   } req_type;

   typedef struct packed {
      logic [NODE_BITS-1:0] path_node;
      logic [COST_BITS-1:0] path_cost;
      logic                 reachable;
      logic                 last;
   } rsp_type;

endpackage

[rtl/core/mgsp_ram.sv]
module mgsp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/multistage_graph_shortest_path.sv]
// Shortest path through a stage-ordered graph. Load transactions (op 0) write one edge
// weight into the MAX_NODES x MAX_NODES weight RAM and are taken one per cycle; weight
// zero removes the edge. A clear transaction (op 2) sweeps the weight RAM one entry per
// cycle, and the same sweep runs straight after reset; no request is taken during the
// sweep, though csr writes are. A solve transaction (op 1) relaxes node j = 1 .. n-1
// from every earlier node, one weight RAM read per cycle, then walks the predecessor
// chain back from the sink, one node RAM read per node, and finally returns the path
// from source to sink, one rsp transaction per cycle while rsp_ready is high. Every
// result carries the saturated total cost; the final one carries last. An unreachable
// sink gives a single result: node 0, cost 0, reachable 0, last 1. The single read port
// of the weight RAM sets the solve time. n is csr_wr_data held to 2 .. min(MAX_NODES, 16);
// write it only while the block is idle.
module multistage_graph_shortest_path #(
   parameter int MAX_NODES   = 16,
   parameter int WEIGHT_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  mgsp_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output mgsp_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_wr_en,
   input  logic [mgsp_pkg::COUNT_BITS-1:0]      csr_wr_data
);

   // Sizes of the stores.
   localparam int TOP       = MAX_NODES < mgsp_pkg::RESULT_LIMIT ?
                              MAX_NODES : mgsp_pkg::RESULT_LIMIT;
   localparam int MAT_DEPTH = MAX_NODES * MAX_NODES;
   localparam int MAT_AW    = $clog2(MAT_DEPTH);
   localparam int NODE_AW   = $clog2(TOP);
   localparam int NODE_W    = mgsp_pkg::COST_BITS + mgsp_pkg::NODE_BITS;
   localparam int WIN_BITS  = WEIGHT_BITS < mgsp_pkg::WEIGHT_FIELD_BITS ?
                              WEIGHT_BITS : mgsp_pkg::WEIGHT_FIELD_BITS;
   localparam int SUM_W     = (WEIGHT_BITS > mgsp_pkg::COST_BITS ?
                               WEIGHT_BITS : mgsp_pkg::COST_BITS) + 1;
   localparam int NB        = mgsp_pkg::NODE_BITS;
   localparam int CB        = mgsp_pkg::COST_BITS;
   localparam logic [NB-1:0] PTR_END = NB'(mgsp_pkg::RESULT_LIMIT - 1);

   typedef enum logic [8:0] {
      ST_CLEAR      = 9'b000000001,
      ST_IDLE       = 9'b000000010,
      ST_INIT       = 9'b000000100,
      ST_RELAX      = 9'b000001000,
      ST_FLUSH      = 9'b000010000,
      ST_COMMIT     = 9'b000100000,
      ST_TRACE      = 9'b001000000,
      ST_TRACE_WAIT = 9'b010000000,
      ST_EMIT       = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   logic [mgsp_pkg::COUNT_BITS-1:0] node_count_ff, node_count_in;
   logic [MAT_AW-1:0]               clr_addr_ff, clr_addr_in;
   logic [NB-1:0]                   j_ff, j_in;
   logic [NB-1:0]                   r_ff, r_in;
   logic [NB-1:0]                   pr_ff, pr_in;
   logic                            pv_ff, pv_in;
   logic [TOP-1:0]                  reached_ff, reached_in;
   logic [CB-1:0]                   acc_cost_ff, acc_cost_in;
   logic [NB-1:0]                   acc_pred_ff, acc_pred_in;
   logic                            acc_hit_ff, acc_hit_in;
   logic [CB-1:0]                   total_cost_ff, total_cost_in;
   logic                            reach_ff, reach_in;
   logic [NB-1:0]                   x_ff, x_in;
   logic [NB-1:0]                   ptr_ff, ptr_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   mgsp_pkg::rsp_type               rsp_data_ff, rsp_data_in;

   // Path buffer: filled from the top end, sink first, and read out source first.
   logic [NB-1:0] path_buf_ff [mgsp_pkg::RESULT_LIMIT];
   logic          pb_we;
   logic [NB-1:0] pb_waddr;
   logic [NB-1:0] pb_wdata;

   // Weight RAM ports.
   logic                   mat_we;
   logic [MAT_AW-1:0]      mat_waddr;
   logic [WEIGHT_BITS-1:0] mat_wdata;
   logic [MAT_AW-1:0]      mat_raddr;
   logic [WEIGHT_BITS-1:0] mat_rdata;

   // Node RAM ports: best cost and predecessor of each node.
   logic                   node_we;
   logic [NODE_AW-1:0]     node_waddr;
   logic [NODE_W-1:0]      node_wdata;
   logic [NODE_AW-1:0]     node_raddr;
   logic [NODE_W-1:0]      node_rdata;

   logic                   req_accept;
   logic                   load_in_range;
   logic [MAT_AW-1:0]      load_addr;
   logic [WEIGHT_BITS-1:0] load_weight;
   logic [mgsp_pkg::COUNT_BITS-1:0] n_use;
   logic [NB-1:0]          sink;

   // Relaxation datapath on the cycle after the reads.
   logic [CB-1:0]          cost_r;
   logic                   hit_r;
   logic [SUM_W-1:0]       sum;
   logic [CB-1:0]          cand;
   logic                   take;

   mgsp_ram #(
      .WIDTH (WEIGHT_BITS),
      .DEPTH (MAT_DEPTH)
   ) u_weight_ram (
      .clock   (clock),
      .wr_en   (mat_we),
      .wr_addr (mat_waddr),
      .wr_data (mat_wdata),
      .rd_addr (mat_raddr),
      .rd_data (mat_rdata)
   );

   mgsp_ram #(
      .WIDTH (NODE_W),
      .DEPTH (TOP)
   ) u_node_ram (
      .clock   (clock),
      .wr_en   (node_we),
      .wr_addr (node_waddr),
      .wr_data (node_wdata),
      .rd_addr (node_raddr),
      .rd_data (node_rdata)
   );

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_accept = req_valid && req_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   // Hold n to the usable range; the sink is the last node in use.
   always_comb begin
      if (node_count_ff < mgsp_pkg::COUNT_BITS'(2)) begin
         n_use = mgsp_pkg::COUNT_BITS'(2);
      end else if (node_count_ff > mgsp_pkg::COUNT_BITS'(TOP)) begin
         n_use = mgsp_pkg::COUNT_BITS'(TOP);
      end else begin
         n_use = node_count_ff;
      end
   end
   assign sink = NB'(n_use - mgsp_pkg::COUNT_BITS'(1));

   // Drop loads that name a node beyond the matrix.
   assign load_in_range = (MAX_NODES >= (1 << NB)) ||
                          ((int'(req_data.from_node) < MAX_NODES) &&
                           (int'(req_data.to_node) < MAX_NODES));
   assign load_addr   = MAT_AW'(int'(req_data.from_node) * MAX_NODES +
                                int'(req_data.to_node));
   assign load_weight = WEIGHT_BITS'(req_data.weight[WIN_BITS-1:0]);

   // Candidate from the node tried on the previous cycle; saturate the sum.
   assign cost_r = node_rdata[NODE_W-1:NB];
   assign hit_r  = reached_ff[pr_ff[NODE_AW-1:0]];
   assign sum    = SUM_W'(cost_r) + SUM_W'(mat_rdata);
   assign cand   = (sum > SUM_W'(mgsp_pkg::COST_MAX)) ? mgsp_pkg::COST_MAX : sum[CB-1:0];
   assign take   = pv_ff && (mat_rdata != '0) && hit_r &&
                   (!acc_hit_ff || (cand < acc_cost_ff));

   always_comb begin
      state_in      = state_ff;
      node_count_in = csr_wr_en ? csr_wr_data : node_count_ff;
      clr_addr_in   = clr_addr_ff;
      j_in          = j_ff;
      r_in          = r_ff;
      pr_in         = r_ff;
      pv_in         = 1'b0;
      reached_in    = reached_ff;
      acc_cost_in   = acc_cost_ff;
      acc_pred_in   = acc_pred_ff;
      acc_hit_in    = acc_hit_ff;
      total_cost_in = total_cost_ff;
      reach_in      = reach_ff;
      x_in          = x_ff;
      ptr_in        = ptr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;

      mat_we     = 1'b0;
      mat_waddr  = load_addr;
      mat_wdata  = load_weight;
      mat_raddr  = MAT_AW'(int'(r_ff) * MAX_NODES + int'(j_ff));
      node_we    = 1'b0;
      node_waddr = j_ff[NODE_AW-1:0];
      node_wdata = {acc_cost_ff, acc_pred_ff};
      node_raddr = r_ff[NODE_AW-1:0];
      pb_we      = 1'b0;
      pb_waddr   = ptr_ff;
      pb_wdata   = x_ff;

      // Fold the candidate read on the previous cycle into the running best.
      if (take) begin
         acc_cost_in = cand;
         acc_pred_in = pr_ff;
         acc_hit_in  = 1'b1;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            mat_we      = 1'b1;
            mat_waddr   = clr_addr_ff;
            mat_wdata   = '0;
            clr_addr_in = clr_addr_ff + MAT_AW'(1);
            if (clr_addr_ff == MAT_AW'(MAT_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               unique case (req_data.op)
                  mgsp_pkg::OP_LOAD: begin
                     mat_we = load_in_range;
                  end
                  mgsp_pkg::OP_SOLVE: begin
                     state_in = ST_INIT;
                  end
                  mgsp_pkg::OP_CLEAR: begin
                     clr_addr_in = '0;
                     state_in    = ST_CLEAR;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_INIT: begin
            // Seed the source: cost zero, reached.
            node_we     = 1'b1;
            node_waddr  = '0;
            node_wdata  = '0;
            reached_in  = TOP'(1);
            j_in        = NB'(1);
            r_in        = '0;
            acc_cost_in = '0;
            acc_pred_in = '0;
            acc_hit_in  = 1'b0;
            state_in    = ST_RELAX;
         end
         ST_RELAX: begin
            // Issue reads of weight[r][j] and best cost of r; later nodes never improve j.
            pv_in = 1'b1;
            if (r_ff == j_ff - NB'(1)) begin
               state_in = ST_FLUSH;
            end else begin
               r_in = r_ff + NB'(1);
            end
         end
         ST_FLUSH: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            node_we                       = 1'b1;
            reached_in[j_ff[NODE_AW-1:0]] = acc_hit_ff;
            acc_cost_in                   = '0;
            acc_pred_in                   = '0;
            acc_hit_in                    = 1'b0;
            if (j_ff == sink) begin
               reach_in = acc_hit_ff;
               ptr_in   = PTR_END;
               if (acc_hit_ff) begin
                  total_cost_in = acc_cost_ff;
                  x_in          = sink;
                  state_in      = ST_TRACE;
               end else begin
                  // Unreachable sink: a single result for node zero.
                  total_cost_in = '0;
                  pb_we         = 1'b1;
                  pb_waddr      = PTR_END;
                  pb_wdata      = '0;
                  state_in      = ST_EMIT;
               end
            end else begin
               j_in     = j_ff + NB'(1);
               r_in     = '0;
               state_in = ST_RELAX;
            end
         end
         ST_TRACE: begin
            pb_we      = 1'b1;
            node_raddr = x_ff[NODE_AW-1:0];
            if (x_ff == '0) begin
               state_in = ST_EMIT;
            end else begin
               ptr_in   = ptr_ff - NB'(1);
               state_in = ST_TRACE_WAIT;
            end
         end
         ST_TRACE_WAIT: begin
            x_in     = node_rdata[NB-1:0];
            state_in = ST_TRACE;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.path_node = path_buf_ff[ptr_ff];
               rsp_data_in.path_cost = total_cost_ff;
               rsp_data_in.reachable = reach_ff;
               rsp_data_in.last      = (ptr_ff == PTR_END);
               if (ptr_ff == PTR_END) begin
                  state_in = ST_IDLE;
               end else begin
                  ptr_in = ptr_ff + NB'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         node_count_ff <= mgsp_pkg::NODE_COUNT_RESET;
         clr_addr_ff   <= '0;
         pv_ff         <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         node_count_ff <= node_count_in;
         clr_addr_ff   <= clr_addr_in;
         pv_ff         <= pv_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      j_ff          <= j_in;
      r_ff          <= r_in;
      pr_ff         <= pr_in;
      reached_ff    <= reached_in;
      acc_cost_ff   <= acc_cost_in;
      acc_pred_ff   <= acc_pred_in;
      acc_hit_ff    <= acc_hit_in;
      total_cost_ff <= total_cost_in;
      reach_ff      <= reach_in;
      x_ff          <= x_in;
      ptr_ff        <= ptr_in;
      rsp_data_ff   <= rsp_data_in;
      if (pb_we) begin
         path_buf_ff[pb_waddr] <= pb_wdata;
      end
   end

endmodule

[rtl/core/mgsp_checker.sv]
`include "multistage_graph_shortest_path_defines.svh"

module mgsp_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input mgsp_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input mgsp_pkg::rsp_type rsp_data
);

   `MGSP_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data), "rsp transaction changed while stalled")
   `MGSP_ASSERT_ALWAYS(a_reset_sweep, reset |=> !req_ready, "request taken during the clearing sweep")
   `MGSP_ASSERT(a_solve_busy, req_valid && req_ready && req_data.op == mgsp_pkg::OP_SOLVE |=> !req_ready, "request taken while solving")
   `MGSP_ASSERT(a_path_pending, rsp_valid && !rsp_data.last |-> !req_ready, "request taken before the path was sent")
   `MGSP_ASSERT(a_unreachable, rsp_valid && !rsp_data.reachable |-> rsp_data.last && rsp_data.path_node == '0 && rsp_data.path_cost == '0, "malformed unreachable result")

endmodule

bind multistage_graph_shortest_path mgsp_checker u_mgsp_checker (.*);

[bench/tb.sv]
`timescale 1ns / 100ps

module tb;

   localparam int NODES        = 16;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int DRAIN_CYCLES = 320;   // covers a full matrix clear sweep
   localparam int HOLD_CYCLES  = 400;
   localparam int PHASE_ITEMS  = 56;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_valid   = 1'b0;
   logic              req_ready;
   mgsp_pkg::req_type req_data    = '0;
   logic              rsp_valid;
   logic              rsp_ready   = 1'b0;
   mgsp_pkg::rsp_type rsp_data;
   logic              csr_wr_en   = 1'b0;
   logic [mgsp_pkg::COUNT_BITS-1:0] csr_wr_data = '0;

   // Shadow of the block's state: weight matrix and node count register.
   logic [mgsp_pkg::WEIGHT_FIELD_BITS-1:0] edge_w [NODES][NODES] = '{default: '0};
   logic [mgsp_pkg::COUNT_BITS-1:0]        count_reg = mgsp_pkg::NODE_COUNT_RESET;

   mgsp_pkg::req_type pending_reqs [$];   // transactions still to be offered
   mgsp_pkg::rsp_type path_expect [$];    // path nodes still to come back
   int unsigned fault_count  = 0;
   int unsigned cycle_count  = 0;
   int unsigned solves_taken = 0;
   int unsigned send_wait    = 0;
   int unsigned recv_wait    = 0;
   int unsigned recv_draw;
   int unsigned queued_count = 0;
   logic        send_burst   = 1'b0;
   logic        recv_burst   = 1'b0;
   logic        long_hold    = 1'b0;

   multistage_graph_shortest_path u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 0;
   end

   // Node count as the block uses it: held to 2 .. 16.
   function automatic int unsigned active_nodes();
      if (count_reg < 2) return 2;
      if (count_reg > NODES) return NODES;
      return 32'(count_reg);
   endfunction

   // Relax every node from every node in index order, then trace the
   // predecessors back from the sink and queue the path, source first.
   function automatic void predict_path();
      logic [mgsp_pkg::COST_BITS-1:0] cost [NODES];
      logic [mgsp_pkg::NODE_BITS-1:0] pred [NODES];
      logic                           reached [NODES];
      logic [mgsp_pkg::NODE_BITS-1:0] route [NODES];
      logic [mgsp_pkg::COST_BITS:0]   sum;
      mgsp_pkg::rsp_type              item;
      int unsigned                    n, j, src, len, x, i;
      n = active_nodes();
      for (j = 0; j < NODES; j++) begin
         cost[j]    = '0;
         pred[j]    = '0;
         reached[j] = 1'b0;
      end
      reached[0] = 1'b1;
      for (j = 1; j < n; j++) begin
         for (src = 0; src < n; src++) begin
            if (edge_w[src][j] != 0 && reached[src]) begin
               sum = {1'b0, cost[src]} + (mgsp_pkg::COST_BITS + 1)'(edge_w[src][j]);
               if (sum > {1'b0, mgsp_pkg::COST_MAX}) sum = {1'b0, mgsp_pkg::COST_MAX};
               // ties keep the earlier source
               if (!reached[j] || sum[mgsp_pkg::COST_BITS-1:0] < cost[j]) begin
                  cost[j]    = sum[mgsp_pkg::COST_BITS-1:0];
                  pred[j]    = mgsp_pkg::NODE_BITS'(src);
                  reached[j] = 1'b1;
               end
            end
         end
      end
      if (!reached[n-1]) begin
         // unreachable sink: a single flagged transaction
         item = '{path_node: '0, path_cost: '0, reachable: 1'b0, last: 1'b1};
         path_expect.push_back(item);
         return;
      end
      len = 1;
      x   = n - 1;
      while (x != 0 && len < mgsp_pkg::RESULT_LIMIT) begin
         x = 32'(pred[x]);
         len++;
      end
      x = n - 1;
      for (i = len; i > 0; i--) begin
         route[i-1] = mgsp_pkg::NODE_BITS'(x);
         x = 32'(pred[x]);
      end
      route[0] = '0;
      for (i = 0; i < len; i++) begin
         item.path_node = route[i];
         item.path_cost = cost[n-1];
         item.reachable = 1'b1;
         item.last      = (i + 1 == len);
         path_expect.push_back(item);
      end
   endfunction

   // Advance the shadow state by one accepted transaction.
   function automatic void apply_request(mgsp_pkg::req_type t);
      int unsigned a, b;
      case (t.op)
         mgsp_pkg::OP_LOAD:  edge_w[t.from_node][t.to_node] = t.weight;
         mgsp_pkg::OP_SOLVE: predict_path();
         mgsp_pkg::OP_CLEAR: begin
            for (a = 0; a < NODES; a++)
               for (b = 0; b < NODES; b++)
                  edge_w[a][b] = '0;
         end
         default: ;   // unused op: nothing changes
      endcase
   endfunction

   function automatic void note_fault(string msg);
      fault_count++;
      if (fault_count <= 10) $display("%s", msg);
   endfunction

   function automatic void check_result(mgsp_pkg::rsp_type got);
      mgsp_pkg::rsp_type want;
      if (path_expect.size() == 0) begin
         note_fault($sformatf("unexpected result: node %0d cost %0d reach %0b last %0b",
                              got.path_node, got.path_cost, got.reachable, got.last));
         return;
      end
      want = path_expect.pop_front();
      if (got.path_node !== want.path_node || got.path_cost !== want.path_cost ||
          got.reachable !== want.reachable || got.last !== want.last)
         note_fault($sformatf({"result mismatch: expected node %0d cost %0d reach %0b ",
                               "last %0b, got node %0d cost %0d reach %0b last %0b"},
                              want.path_node, want.path_cost, want.reachable, want.last,
                              got.path_node, got.path_cost, got.reachable, got.last));
   endfunction

   // Driver: offer the next pending transaction after a random gap, hold it
   // steady until the block takes it, and predict at the accepting edge.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_wait <= 0;
      end else begin
         if ($urandom_range(0, 39) == 0) send_burst <= !send_burst;
         if (!req_valid || req_ready) begin
            if (req_valid) begin
               apply_request(req_data);
               if (req_data.op == mgsp_pkg::OP_SOLVE) solves_taken <= solves_taken + 1;
            end
            if (send_wait != 0) begin
               req_valid <= 1'b0;
               send_wait <= send_wait - 1;
            end else if (pending_reqs.size() == 0) begin
               req_valid <= 1'b0;
            end else begin
               req_data  <= pending_reqs.pop_front();
               req_valid <= 1'b1;
               send_wait <= send_burst ? 0 : $urandom_range(0, 6);
            end
         end
      end
   end

   // Monitor: check each accepted result transaction, then drop ready for a
   // random number of cycles; the long hold overrides everything.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_wait <= 0;
      end else begin
         if ($urandom_range(0, 29) == 0) recv_burst <= !recv_burst;
         if (rsp_valid && rsp_ready) begin
            check_result(rsp_data);
            recv_draw = recv_burst ? 0 : $urandom_range(0, 6);
            recv_wait <= recv_draw;
            rsp_ready <= (recv_draw == 0) && !long_hold;
         end else if (recv_wait != 0) begin
            recv_wait <= recv_wait - 1;
            rsp_ready <= (recv_wait == 1) && !long_hold;
         end else begin
            rsp_ready <= !long_hold;
         end
      end
   end

   // Back-pressure: once a few solves are in, refuse results for a long
   // stretch while the driver keeps offering, so the block stalls its input.
   initial begin
      wait (solves_taken >= 3);
      @(posedge clock);
      long_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      long_hold <= 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   function automatic void queue_req(logic [1:0] op,
                                     logic [mgsp_pkg::NODE_BITS-1:0] from_node,
                                     logic [mgsp_pkg::NODE_BITS-1:0] to_node,
                                     logic [mgsp_pkg::WEIGHT_FIELD_BITS-1:0] weight);
      mgsp_pkg::req_type t;
      t = '{op: op, from_node: from_node, to_node: to_node, weight: weight};
      pending_reqs.push_back(t);
      if (op != OP_UNUSED) queued_count++;
   endfunction

   // Edge weights lean towards the extremes.
   function automatic logic [mgsp_pkg::WEIGHT_FIELD_BITS-1:0] draw_weight();
      case ($urandom_range(0, 5))
         0:       return '1;
         1:       return 16'd1;
         2:       return mgsp_pkg::WEIGHT_FIELD_BITS'($urandom_range(1, 15));
         default: return mgsp_pkg::WEIGHT_FIELD_BITS'($urandom);
      endcase
   endfunction

   // Wait until every transaction is taken and every result is back, then
   // let a clear sweep that may still be running finish.
   task automatic settle();
      while (pending_reqs.size() != 0 || req_valid || path_expect.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_node_count(logic [mgsp_pkg::COUNT_BITS-1:0] value);
      settle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      count_reg    = value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Mostly stage-ordered graphs with random content, either built afresh
   // or altered a few edges at a time, each closed by a solve; the rest is
   // noise with every field random.
   task automatic build_phase(int unsigned budget);
      int unsigned n, start, j, k, fan, pick, src;
      @(negedge clock);
      n     = active_nodes();
      start = queued_count;
      while (queued_count - start < budget) begin
         pick = $urandom_range(0, 9);
         if (pick < 3) begin
            if ($urandom_range(0, 2) != 0)
               queue_req(mgsp_pkg::OP_CLEAR, mgsp_pkg::NODE_BITS'($urandom),
                         mgsp_pkg::NODE_BITS'($urandom),
                         mgsp_pkg::WEIGHT_FIELD_BITS'($urandom));
            for (j = 1; j < n; j++) begin
               fan = $urandom_range(1, 3);
               for (k = 0; k < fan; k++)
                  queue_req(mgsp_pkg::OP_LOAD, mgsp_pkg::NODE_BITS'($urandom_range(0, j - 1)),
                            mgsp_pkg::NODE_BITS'(j), draw_weight());
            end
            queue_req(mgsp_pkg::OP_SOLVE, mgsp_pkg::NODE_BITS'($urandom),
                      mgsp_pkg::NODE_BITS'($urandom), mgsp_pkg::WEIGHT_FIELD_BITS'($urandom));
         end else if (pick < 8) begin
            fan = $urandom_range(0, 4);
            for (k = 0; k < fan; k++) begin
               src = $urandom_range(0, n - 2);
               queue_req(mgsp_pkg::OP_LOAD, mgsp_pkg::NODE_BITS'(src),
                         mgsp_pkg::NODE_BITS'($urandom_range(src + 1, n - 1)),
                         ($urandom_range(0, 7) == 0) ? '0 : draw_weight());
            end
            queue_req(mgsp_pkg::OP_SOLVE, mgsp_pkg::NODE_BITS'($urandom),
                      mgsp_pkg::NODE_BITS'($urandom), mgsp_pkg::WEIGHT_FIELD_BITS'($urandom));
         end else begin
            queue_req(2'($urandom_range(0, 3)), mgsp_pkg::NODE_BITS'($urandom),
                      mgsp_pkg::NODE_BITS'($urandom), mgsp_pkg::WEIGHT_FIELD_BITS'($urandom));
         end
      end
   endtask

   logic [mgsp_pkg::COUNT_BITS-1:0] count_plan [8] =
      '{5'd2, 5'd0, 5'd31, 5'd1, 5'd16, 5'd5, 5'd9, 5'd16};

   initial begin
      int unsigned p;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part at the reset node count.
      queue_req(mgsp_pkg::OP_SOLVE, '1, '1, '1);             // empty matrix: sink unreachable
      queue_req(mgsp_pkg::OP_LOAD, 4'd0, 4'd15, 16'hFFFF);   // direct edge, largest weight
      queue_req(mgsp_pkg::OP_SOLVE, '0, '0, '0);
      queue_req(mgsp_pkg::OP_LOAD, 4'd0, 4'd1, 16'd1);
      queue_req(mgsp_pkg::OP_LOAD, 4'd1, 4'd15, 16'd1);
      queue_req(mgsp_pkg::OP_SOLVE, '0, '0, '0);
      queue_req(mgsp_pkg::OP_LOAD, 4'd0, 4'd2, 16'd1);       // equal cost: keep the earlier node
      queue_req(mgsp_pkg::OP_LOAD, 4'd2, 4'd15, 16'd1);
      queue_req(mgsp_pkg::OP_SOLVE, '0, '0, '0);
      queue_req(mgsp_pkg::OP_LOAD, 4'd5, 4'd5, 16'd3);       // self loop
      queue_req(mgsp_pkg::OP_LOAD, 4'd15, 4'd3, 16'd1);      // edge from a later node
      queue_req(mgsp_pkg::OP_LOAD, 4'd3, 4'd15, 16'd1);      // only reachable through the back edge
      queue_req(mgsp_pkg::OP_SOLVE, '0, '0, '0);
      queue_req(mgsp_pkg::OP_LOAD, 4'd1, 4'd15, 16'd0);      // weight zero removes the edge
      queue_req(mgsp_pkg::OP_SOLVE, '0, '0, '0);
      queue_req(OP_UNUSED, '1, '1, '1);                      // unused op: no effect
      queue_req(mgsp_pkg::OP_SOLVE, '0, '0, '0);
      queue_req(mgsp_pkg::OP_CLEAR, '0, '0, '0);
      queue_req(mgsp_pkg::OP_SOLVE, '0, '0, '0);             // cleared: unreachable again

      count_plan[5] = mgsp_pkg::COUNT_BITS'($urandom_range(3, 15));
      for (p = 0; p < 8; p++) begin
         write_node_count(count_plan[p]);
         build_phase(PHASE_ITEMS);
      end

      settle();
      if (fault_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
